>>> hdl/crc16_ascii_frame_checker_assert.svh
// Assertion macros shared by the frame checker modules.
`ifndef CRC16_ASCII_FRAME_CHECKER_ASSERT_SVH
`define CRC16_ASCII_FRAME_CHECKER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CAFC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cafc assertion failed");

// Next-cycle implication, checked out of reset.
`define CAFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cafc assertion failed");

`endif

>>> hdl/cafc_pkg.sv
// Types, constants and helper functions for the CRC-16 frame checker.
package cafc_pkg;

  localparam int COUNT_WIDTH_DEF = 13;
  localparam int LEN_W           = 13;
  localparam int CAP_W           = 12;
  localparam int CRC_W           = 16;

  localparam logic [CAP_W-1:0] CAP_RESET   = 12'd160;
  localparam logic [LEN_W-1:0] OUT_LEN_MAX = 13'd8191;
  localparam logic [CRC_W-1:0] CRC_INIT    = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY    = 16'h1021;
  localparam logic [2:0]       CRC_DIGITS  = 3'd4;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_0      = 8'h30;
  localparam logic [7:0] CHAR_9      = 8'h39;
  localparam logic [7:0] CHAR_UA     = 8'h41;
  localparam logic [7:0] CHAR_UF     = 8'h46;
  localparam logic [7:0] CHAR_LA     = 8'h61;
  localparam logic [7:0] CHAR_LF     = 8'h66;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CRC_ERR  = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       is_end;
  } cafc_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             framed;
    logic [LEN_W-1:0] payload_length;
    logic [CRC_W-1:0] crc_received;
    logic [CRC_W-1:0] crc_computed;
  } cafc_result_t;

  // MSB-first CRC-16 update over one byte
  function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [7:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // {digit valid, nibble}
  function automatic logic [4:0] hex_digit(input logic [7:0] ch);
    logic [7:0] d;
    d = 8'h00;
    priority if (ch >= CHAR_0 && ch <= CHAR_9) begin
      d = ch - CHAR_0;
      return {1'b1, d[3:0]};
    end else if (ch >= CHAR_UA && ch <= CHAR_UF) begin
      d = ch - CHAR_UA + 8'd10;
      return {1'b1, d[3:0]};
    end else if (ch >= CHAR_LA && ch <= CHAR_LF) begin
      d = ch - CHAR_LA + 8'd10;
      return {1'b1, d[3:0]};
    end else begin
      return 5'b0_0000;
    end
  endfunction

endpackage

>>> hdl/cafc_in_if.sv
// Input character channel: valid/ready plus one line character.
interface cafc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       is_end;

  modport source (output valid, output char_byte, output is_end, input ready);
  modport sink   (input valid, input char_byte, input is_end, output ready);
endinterface

>>> hdl/cafc_out_if.sv
// Verdict channel: valid/ready plus one line verdict.
interface cafc_out_if import cafc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic             framed;
  logic [LEN_W-1:0] payload_length;
  logic [CRC_W-1:0] crc_received;
  logic [CRC_W-1:0] crc_computed;

  modport source (output valid, output status, output framed, output payload_length,
                  output crc_received, output crc_computed, input ready);
  modport sink   (input valid, input status, input framed, input payload_length,
                  input crc_received, input crc_computed, output ready);
endinterface

>>> hdl/cafc_in_stage.sv
// Input register stage holding one character request.
module cafc_in_stage import cafc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  cafc_item_t in_item,
  output logic       item_v,
  output cafc_item_t item,
  input  logic       item_take
);

  logic       item_v_r, item_v_nxt;
  cafc_item_t item_r;

  assign in_ready   = !item_v_r || item_take;
  assign item_v_nxt = (in_valid && in_ready) ? 1'b1 : (item_take ? 1'b0 : item_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else begin
      item_v_r <= item_v_nxt;
    end
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_v = item_v_r;
  assign item   = item_r;

endmodule

>>> hdl/cafc_line_core.sv
// Per-line parser state, running CRC and verdict logic.
module cafc_line_core import cafc_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data,
  input  logic             item_v,
  input  cafc_item_t       item,
  output logic             item_take,
  input  logic             res_ready,
  output logic             res_push,
  output cafc_result_t     res
);

`include "crc16_ascii_frame_checker_assert.svh"

  localparam int CW = COUNT_WIDTH;
  localparam int LW = (CW > LEN_W) ? CW : LEN_W;
  localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};

  logic [CAP_W-1:0] cap_r;
  logic             at_start_r, at_start_nxt;
  logic             frame_r, frame_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CRC_W-1:0] crc_r, crc_nxt;
  logic [CRC_W-1:0] crc_star_r, crc_star_nxt;
  logic [CW-1:0]    count_star_r, count_star_nxt;
  logic             star_r, star_nxt;
  logic [2:0]       cas_r, cas_nxt;
  logic [CRC_W-1:0] hex_r, hex_nxt;
  logic             halted_r, halted_nxt;

  logic [4:0]       hexd;
  logic [CW-1:0]    len;
  logic [LW-1:0]    len_ext;
  logic             char_take;

  assign item_take = item_v && (!item.is_end || res_ready);
  assign res_push  = item_v && item.is_end && res_ready;
  assign char_take = item_v && !item.is_end;
  assign hexd      = hex_digit(item.char_byte);

  // Character update, and line state cleared when a verdict is pushed
  always_comb begin
    at_start_nxt   = at_start_r;
    frame_nxt      = frame_r;
    count_nxt      = count_r;
    crc_nxt        = crc_r;
    crc_star_nxt   = crc_star_r;
    count_star_nxt = count_star_r;
    star_nxt       = star_r;
    cas_nxt        = cas_r;
    hex_nxt        = hex_r;
    halted_nxt     = halted_r;
    if (res_push) begin
      at_start_nxt   = 1'b1;
      frame_nxt      = 1'b0;
      count_nxt      = '0;
      crc_nxt        = CRC_INIT;
      crc_star_nxt   = CRC_INIT;
      count_star_nxt = '0;
      star_nxt       = 1'b0;
      cas_nxt        = '0;
      hex_nxt        = '0;
      halted_nxt     = 1'b0;
    end else if (char_take) begin
      at_start_nxt = 1'b0;
      if (at_start_r && item.char_byte == CHAR_DOLLAR) begin
        frame_nxt = 1'b1;
      end else begin
        if (frame_r && item.char_byte == CHAR_STAR) begin
          crc_star_nxt   = crc_r;
          count_star_nxt = count_r;
          star_nxt       = 1'b1;
          cas_nxt        = '0;
          hex_nxt        = '0;
          halted_nxt     = 1'b0;
        end else if (frame_r && star_r && cas_r < CRC_DIGITS) begin
          if (!halted_r) begin
            if (!hexd[4]) begin
              halted_nxt = 1'b1;
            end else begin
              hex_nxt = {hex_r[11:0], hexd[3:0]};
            end
          end
          cas_nxt = cas_r + 3'd1;
        end
        crc_nxt = crc16_byte(crc_r, item.char_byte);
        if (count_r != COUNT_MAX) begin
          count_nxt = count_r + 1'b1;
        end
      end
    end
  end

  // Verdict at the terminator
  assign len     = (frame_r && star_r) ? count_star_r : count_r;
  assign len_ext = LW'(len);

  always_comb begin
    res.framed         = frame_r;
    res.payload_length = (len_ext > LW'(OUT_LEN_MAX)) ? OUT_LEN_MAX : len_ext[LEN_W-1:0];
    res.crc_received   = (frame_r && star_r) ? hex_r : '0;
    res.crc_computed   = (frame_r && star_r) ? crc_star_r : crc_r;
    priority if (!frame_r) begin
      res.status = (len_ext >= LW'(cap_r)) ? ST_TOO_LONG : ST_OK;
    end else if (!star_r || cas_r < CRC_DIGITS) begin
      res.status = ST_CRC_ERR;
    end else if (len_ext >= LW'(cap_r)) begin
      res.status = ST_TOO_LONG;
    end else begin
      res.status = (hex_r == crc_star_r) ? ST_OK : ST_CRC_ERR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r        <= CAP_RESET;
      at_start_r   <= 1'b1;
      frame_r      <= 1'b0;
      count_r      <= '0;
      crc_r        <= CRC_INIT;
      crc_star_r   <= CRC_INIT;
      count_star_r <= '0;
      star_r       <= 1'b0;
      cas_r        <= '0;
      hex_r        <= '0;
      halted_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      at_start_r   <= at_start_nxt;
      frame_r      <= frame_nxt;
      count_r      <= count_nxt;
      crc_r        <= crc_nxt;
      crc_star_r   <= crc_star_nxt;
      count_star_r <= count_star_nxt;
      star_r       <= star_nxt;
      cas_r        <= cas_nxt;
      hex_r        <= hex_nxt;
      halted_r     <= halted_nxt;
    end
  end

  `CAFC_ASSERT_NEXT(a_line_clear, res_push, at_start_r && !frame_r && !star_r && count_r == '0)
  `CAFC_ASSERT_IMPL(a_digit_bound, 1'b1, cas_r <= CRC_DIGITS)
  `CAFC_ASSERT_IMPL(a_star_in_frame, star_r, frame_r && !at_start_r)

endmodule

>>> hdl/cafc_res_buf.sv
// Two-entry verdict buffer between the line core and the output channel.
module cafc_res_buf import cafc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  cafc_result_t push_data,
  output logic         space,
  output logic         out_valid,
  input  logic         out_ready,
  output cafc_result_t out_data
);

`include "crc16_ascii_frame_checker_assert.svh"

  cafc_result_t ent_r [2];
  logic         wr_r, wr_nxt;
  logic         rd_r, rd_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         pop;

  assign space     = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = ent_r[rd_r];
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_nxt  = push ? !wr_r : wr_r;
    rd_nxt  = pop ? !rd_r : rd_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      ent_r[wr_r] <= push_data;
    end
  end

  `CAFC_ASSERT_IMPL(a_no_overflow, push, cnt_r != 2'd2)
  `CAFC_ASSERT_IMPL(a_ptr_track, 1'b1, cnt_r == 2'd1 ? (wr_r != rd_r) : (wr_r == rd_r))
  `CAFC_ASSERT_NEXT(a_hold_valid, out_valid && !out_ready, out_valid)

endmodule

>>> hdl/crc16_ascii_frame_checker.sv
// Path: accepted terminator -> input register -> verdict buffer entry -> out_chan.valid.
// Throughput: one character or terminator per cycle unless stalled; the CRC update is combinational.
// Input stalls only when a terminator finds both verdict buffer entries full.
// Reset (synchronous, rst_n low): line state cleared, CRC at 0xFFFF, capacity 160,
// input register and verdict buffer empty.
module crc16_ascii_frame_checker import cafc_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data,
  cafc_in_if.sink          in_chan,
  cafc_out_if.source       out_chan
);

  cafc_item_t   in_item;
  cafc_item_t   item;
  logic         item_v;
  logic         item_take;
  logic         res_push;
  logic         res_space;
  cafc_result_t res;
  cafc_result_t out_res;

  assign in_item.char_byte = in_chan.char_byte;
  assign in_item.is_end    = in_chan.is_end;

  cafc_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_item   (in_item),
    .item_v    (item_v),
    .item      (item),
    .item_take (item_take)
  );

  cafc_line_core #(.COUNT_WIDTH(COUNT_WIDTH)) u_line_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item_v      (item_v),
    .item        (item),
    .item_take   (item_take),
    .res_ready   (res_space),
    .res_push    (res_push),
    .res         (res)
  );

  cafc_res_buf u_res_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res),
    .space     (res_space),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_data  (out_res)
  );

  assign out_chan.status         = out_res.status;
  assign out_chan.framed         = out_res.framed;
  assign out_chan.payload_length = out_res.payload_length;
  assign out_chan.crc_received   = out_res.crc_received;
  assign out_chan.crc_computed   = out_res.crc_computed;

endmodule
